// ===== rtl/core/skt_pkg.sv =====
// skt_pkg: types, sizes and codes for the sorted key table core.
// Used by skt_ram, skt_ctrl, sorted_key_table_core and skt_checker.
package skt_pkg;

    localparam int DEPTH   = 256;               // table entries
    localparam int PAY_W   = 32;                // stored payload bits
    localparam int KEY_W   = 32;
    localparam int FIELD_W = 32;                // width of payload fields on the ports
    localparam int POS_W   = 9;                 // width of position / entry_count fields
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1); // holds 0..DEPTH

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_FIND   = 2'd1;
    localparam logic [1:0] CMD_REMOVE = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_EXISTS  = 2'd1;
    localparam logic [1:0] ST_MISSING = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [KEY_W-1:0]   entry_key;
        logic [FIELD_W-1:0] entry_payload;
    } skt_in_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [FIELD_W-1:0] found_payload;
        logic [POS_W-1:0]   position;
        logic [POS_W-1:0]   entry_count;
    } skt_out_t;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [PAY_W-1:0] payload;
    } skt_entry_t;

    // one write and one read port per cycle
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        skt_entry_t        wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } skt_mem_req_t;

endpackage

// ===== rtl/core/skt_ram.sv =====
// skt_ram: entry store of the sorted key table, one write and one read port,
// read data registered. Depends on skt_pkg.
module skt_ram
    import skt_pkg::*;
(
    input  logic         clk,
    input  skt_mem_req_t req,
    output skt_entry_t   rd_data
);

    skt_entry_t mem [DEPTH];
    skt_entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            rd_data_reg <= mem[req.raddr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/skt_ctrl.sv =====
// skt_ctrl: sequencer for search, shift and result of the sorted key table.
// Drives skt_ram through one compare unit. Depends on skt_pkg.
module skt_ctrl
    import skt_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         item_valid,
    output logic         item_ready,
    input  skt_in_t      item,
    output logic         res_valid,
    input  logic         res_ready,
    output skt_out_t     result,
    output skt_mem_req_t mem_req,
    input  skt_entry_t   rd_data
);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_SRCH   = 8'b0000_0010,
        S_SCMP   = 8'b0000_0100,
        S_HCMP   = 8'b0000_1000,
        S_DECIDE = 8'b0001_0000,
        S_UP     = 8'b0010_0000,
        S_DOWN   = 8'b0100_0000,
        S_DONE   = 8'b1000_0000
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  fill_reg, fill_next;
    logic [CNT_W-1:0]  lo_reg, lo_next;
    logic [CNT_W-1:0]  hi_reg, hi_next;
    logic [CNT_W-1:0]  mid_reg, mid_next;
    logic [CNT_W-1:0]  rd_idx_reg, rd_idx_next;
    logic [ADDR_W-1:0] wr_addr_reg, wr_addr_next;
    logic              wr_pend_reg, wr_pend_next;
    logic              hit_reg, hit_next;
    logic [PAY_W-1:0]  pay_reg, pay_next;
    logic [1:0]        cmd_reg, cmd_next;
    logic [KEY_W-1:0]  key_reg, key_next;
    logic [PAY_W-1:0]  payin_reg, payin_next;
    logic [1:0]        status_reg, status_next;
    logic [CNT_W-1:0]  pos_reg, pos_next;
    logic [PAY_W-1:0]  found_reg, found_next;

    logic [CNT_W-1:0]  mid_w;
    logic [CNT_W-1:0]  lo_m1;
    logic [CNT_W-1:0]  rd_m1;

    assign mid_w = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign lo_m1 = lo_reg - CNT_W'(1);
    assign rd_m1 = rd_idx_reg - CNT_W'(1);

    always_comb
    begin
        state_next   = state_reg;
        fill_next    = fill_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        mid_next     = mid_reg;
        rd_idx_next  = rd_idx_reg;
        wr_addr_next = wr_addr_reg;
        wr_pend_next = wr_pend_reg;
        hit_next     = hit_reg;
        pay_next     = pay_reg;
        cmd_next     = cmd_reg;
        key_next     = key_reg;
        payin_next   = payin_reg;
        status_next  = status_reg;
        pos_next     = pos_reg;
        found_next   = found_reg;
        mem_req      = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    cmd_next   = item.cmd;
                    key_next   = item.entry_key;
                    payin_next = PAY_W'(item.entry_payload);
                    lo_next    = '0;
                    hi_next    = fill_reg;
                    hit_next   = 1'b0;
                    found_next = '0;
                    if (item.cmd == CMD_INSERT || item.cmd == CMD_FIND ||
                        item.cmd == CMD_REMOVE)
                    begin
                        state_next = S_SRCH;
                    end
                    else
                    begin
                        status_next = ST_MISSING;
                        pos_next    = '0;
                        state_next  = S_DONE;
                    end
                end
            end
            S_SRCH:
            begin
                if (lo_reg < hi_reg)
                begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = mid_w[ADDR_W-1:0];
                    mid_next      = mid_w;
                    state_next    = S_SCMP;
                end
                else if (lo_reg != '0)
                begin
                    // upper bound found; check the entry just below it
                    mem_req.re    = 1'b1;
                    mem_req.raddr = lo_m1[ADDR_W-1:0];
                    state_next    = S_HCMP;
                end
                else
                begin
                    hit_next   = 1'b0;
                    state_next = S_DECIDE;
                end
            end
            S_SCMP:
            begin
                if (rd_data.key <= key_reg)
                begin
                    lo_next = mid_reg + CNT_W'(1);
                end
                else
                begin
                    hi_next = mid_reg;
                end
                state_next = S_SRCH;
            end
            S_HCMP:
            begin
                hit_next   = (rd_data.key == key_reg);
                pay_next   = rd_data.payload;
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                priority if (cmd_reg == CMD_INSERT)
                begin
                    if (hit_reg)
                    begin
                        status_next = ST_EXISTS;
                        pos_next    = lo_m1;
                        state_next  = S_DONE;
                    end
                    else if (fill_reg == CNT_W'(DEPTH))
                    begin
                        status_next = ST_FULL;
                        pos_next    = lo_reg;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        rd_idx_next  = fill_reg;
                        wr_pend_next = 1'b0;
                        state_next   = S_UP;
                    end
                end
                else if (hit_reg)
                begin
                    status_next = ST_OK;
                    pos_next    = lo_m1;
                    found_next  = pay_reg;
                    if (cmd_reg == CMD_REMOVE)
                    begin
                        rd_idx_next  = lo_reg;
                        wr_pend_next = 1'b0;
                        state_next   = S_DOWN;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    status_next = ST_MISSING;
                    pos_next    = lo_reg;
                    state_next  = S_DONE;
                end
            end
            S_UP:
            begin
                // read j-1 while writing the entry read last cycle to j
                if (wr_pend_reg)
                begin
                    mem_req.we    = 1'b1;
                    mem_req.waddr = wr_addr_reg;
                    mem_req.wdata = rd_data;
                end
                if (rd_idx_reg > lo_reg)
                begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = rd_m1[ADDR_W-1:0];
                    wr_addr_next  = rd_idx_reg[ADDR_W-1:0];
                    rd_idx_next   = rd_m1;
                    wr_pend_next  = 1'b1;
                end
                else
                begin
                    wr_pend_next = 1'b0;
                    if (!wr_pend_reg)
                    begin
                        mem_req.we              = 1'b1;
                        mem_req.waddr           = lo_reg[ADDR_W-1:0];
                        mem_req.wdata.key       = key_reg;
                        mem_req.wdata.payload   = payin_reg;
                        fill_next   = fill_reg + CNT_W'(1);
                        status_next = ST_OK;
                        pos_next    = lo_reg;
                        state_next  = S_DONE;
                    end
                end
            end
            S_DOWN:
            begin
                if (wr_pend_reg)
                begin
                    mem_req.we    = 1'b1;
                    mem_req.waddr = wr_addr_reg;
                    mem_req.wdata = rd_data;
                end
                if (rd_idx_reg < fill_reg)
                begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = rd_idx_reg[ADDR_W-1:0];
                    wr_addr_next  = rd_m1[ADDR_W-1:0];
                    rd_idx_next   = rd_idx_reg + CNT_W'(1);
                    wr_pend_next  = 1'b1;
                end
                else
                begin
                    wr_pend_next = 1'b0;
                    if (!wr_pend_reg)
                    begin
                        fill_next  = fill_reg - CNT_W'(1);
                        state_next = S_DONE;
                    end
                end
            end
            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            fill_reg    <= '0;
            wr_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            wr_pend_reg <= wr_pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        mid_reg     <= mid_next;
        rd_idx_reg  <= rd_idx_next;
        wr_addr_reg <= wr_addr_next;
        hit_reg     <= hit_next;
        pay_reg     <= pay_next;
        cmd_reg     <= cmd_next;
        key_reg     <= key_next;
        payin_reg   <= payin_next;
        status_reg  <= status_next;
        pos_reg     <= pos_next;
        found_reg   <= found_next;
    end

    assign item_ready = (state_reg == S_IDLE);
    assign res_valid  = (state_reg == S_DONE);

    assign result.status        = status_reg;
    assign result.found_payload = FIELD_W'(found_reg);
    assign result.position      = POS_W'(pos_reg);
    assign result.entry_count   = POS_W'(fill_reg);

endmodule

// ===== rtl/core/sorted_key_table_core.sv =====
// sorted_key_table_core: top level of the sorted key table with output register.
// Depends on skt_pkg, skt_ram and skt_ctrl.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-----------------------------
//   in      | input     | in_valid / in_ready  | in_data  (skt_in_t)
//   out     | output    | out_valid / out_ready| out_data (skt_out_t)
//
// Find binary-searches for the upper bound of the key and then checks the entry below it;
// insert then shifts the entries from the sorted place up by one and remove shifts the
// ones above it down, all through skt_ram with its registered read data.
// One command is worked at a time; in_ready is high only while the sequencer idles.
// The result sits in an output register, so a new beat is taken while it waits.
// rst_n empties the table at once; entry contents are not cleared.
module sorted_key_table_core
    import skt_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  skt_in_t  in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output skt_out_t out_data
);

    skt_mem_req_t mem_req;
    skt_entry_t   rd_data;
    logic         res_valid;
    logic         res_ready;
    skt_out_t     result;

    logic         out_valid_reg, out_valid_next;
    skt_out_t     out_data_reg, out_data_next;

    skt_ram u_ram (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    skt_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (in_valid),
        .item_ready (in_ready),
        .item       (in_data),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .result     (result),
        .mem_req    (mem_req),
        .rd_data    (rd_data)
    );

    assign res_ready = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
            out_data_next  = result;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== rtl/core/skt_checker.sv =====
// skt_checker: port-level assertions for sorted_key_table_core, bound to it below.
// Depends on skt_pkg.
module skt_checker
    import skt_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     in_valid,
    input logic     in_ready,
    input logic     out_valid,
    input logic     out_ready,
    input skt_out_t out_data
);

    // a waiting result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("out beat changed while stalled");

    // a command keeps the core busy, so in_ready drops after a beat is taken
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("core ready right after taking a beat");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.entry_count <= POS_W'(DEPTH))
        else $error("entry_count above table depth");

    // payload is only reported on success
    a_payload_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status != ST_OK |-> out_data.found_payload == '0)
        else $error("payload reported on failed command");

endmodule

bind sorted_key_table_core skt_checker u_skt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

// ===== bench/testbench.sv =====
// testbench: self-checking bench for sorted_key_table_core, with a table scoreboard class,
// a beat driver, a result sink with random back-pressure and an idle watchdog.
// Depends on skt_pkg and the sorted_key_table_core RTL.
module testbench;
    import skt_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int RANDOM_BEATS = 1850;
    localparam int IDLE_LIMIT   = 20000;
    localparam int HOLD_CYCLES  = 2500;
    localparam int DRAIN_CYCLES = 400;

    typedef enum {MIX_FILL, MIX_BALANCED, MIX_DRAIN} cmd_mix_t;

    // Keeps its own copy of the table and the results still owed by the block.
    class table_scoreboard;
        logic [KEY_W-1:0]   keys [DEPTH];
        logic [FIELD_W-1:0] payloads [DEPTH];
        int unsigned        fill;
        skt_out_t           due_results [$];
        int                 errors;
        int                 reported;

        function new();
            fill = 0;
            errors = 0;
            reported = 0;
        endfunction

        // number of stored keys <= k
        function int unsigned upper_bound(logic [KEY_W-1:0] k);
            int unsigned lo;
            int unsigned hi;
            int unsigned mid;
            lo = 0;
            hi = fill;
            while (lo < hi)
            begin
                mid = lo + (hi - lo) / 2;
                if (keys[mid] <= k)
                    lo = mid + 1;
                else
                    hi = mid;
            end
            return lo;
        endfunction

        function skt_out_t apply_command(skt_in_t c);
            skt_out_t           r;
            logic [FIELD_W-1:0] pay;
            int unsigned        i;
            int unsigned        j;
            int unsigned        pos;
            bit                 hit;
            for (int b = 0; b < FIELD_W; b++)
                pay[b] = (b < PAY_W) ? c.entry_payload[b] : 1'b0;
            r.status = ST_MISSING;
            r.found_payload = '0;
            pos = 0;
            if (c.cmd == CMD_INSERT || c.cmd == CMD_FIND || c.cmd == CMD_REMOVE)
            begin
                i = upper_bound(c.entry_key);
                hit = 0;
                if (i != 0)
                    hit = (keys[i-1] == c.entry_key);
                pos = i;
                if (c.cmd == CMD_INSERT)
                begin
                    if (hit)
                    begin
                        r.status = ST_EXISTS;
                        pos = i - 1;
                    end
                    else if (fill >= DEPTH)
                        r.status = ST_FULL;
                    else
                    begin
                        for (j = fill; j > i; j--)
                        begin
                            keys[j] = keys[j-1];
                            payloads[j] = payloads[j-1];
                        end
                        keys[i] = c.entry_key;
                        payloads[i] = pay;
                        fill++;
                        r.status = ST_OK;
                    end
                end
                else if (hit)
                begin
                    pos = i - 1;
                    r.found_payload = payloads[pos];
                    r.status = ST_OK;
                    if (c.cmd == CMD_REMOVE)
                    begin
                        for (j = pos; j + 1 < fill; j++)
                        begin
                            keys[j] = keys[j+1];
                            payloads[j] = payloads[j+1];
                        end
                        fill--;
                    end
                end
            end
            r.position = pos[POS_W-1:0];
            r.entry_count = fill[POS_W-1:0];
            return r;
        endfunction

        function void note_command(skt_in_t c);
            due_results.push_back(apply_command(c));
        endfunction

        function void flag(string field, logic [FIELD_W-1:0] e, logic [FIELD_W-1:0] a);
            errors++;
            if (reported < 60)
            begin
                reported++;
                $error("%s: expected 0x%0h, actual 0x%0h", field, e, a);
            end
        endfunction

        function void check_result(skt_out_t r);
            skt_out_t e;
            if (due_results.size() == 0)
            begin
                errors++;
                $error("result beat with nothing expected: 0x%0h", r);
                return;
            end
            e = due_results.pop_front();
            if (r.status !== e.status)
                flag("status", FIELD_W'(e.status), FIELD_W'(r.status));
            if (r.found_payload !== e.found_payload)
                flag("found_payload", e.found_payload, r.found_payload);
            if (r.position !== e.position)
                flag("position", FIELD_W'(e.position), FIELD_W'(r.position));
            if (r.entry_count !== e.entry_count)
                flag("entry_count", FIELD_W'(e.entry_count), FIELD_W'(r.entry_count));
        endfunction

        function void check_leftover();
            if (due_results.size() != 0)
            begin
                errors++;
                $error("%0d expected results never arrived", due_results.size());
            end
        endfunction
    endclass

    logic     clk;
    logic     rst_n = 1'b0;
    logic     in_valid = 1'b0;
    logic     in_ready;
    skt_in_t  in_data = '0;
    logic     out_valid;
    logic     out_ready = 1'b0;
    skt_out_t out_data;

    table_scoreboard sb = new();
    bit  hold_request = 0;
    bit  quiet_mode = 0;
    int  beats_sent = 0;
    int  idle_cycles = 0;

    sorted_key_table_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // monitor and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                sb.note_command(in_data);
            if (out_valid && out_ready)
                sb.check_result(out_data);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else if (idle_cycles + 1 >= IDLE_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 4);
        if (r < 97)
            return $urandom_range(5, 20);
        return $urandom_range(30, 120);
    endfunction

    // result sink: random runs of ready, random stalls, one long hold on request
    initial
    begin
        int run;
        int stall;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_request)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 0;
            end
            else if (quiet_mode)
            begin
                out_ready <= 1'b1;
                @(posedge clk);
            end
            else
            begin
                run = $urandom_range(1, 20);
                out_ready <= 1'b1;
                repeat (run) @(posedge clk);
                stall = pick_gap();
                if (stall > 0)
                begin
                    out_ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
            end
        end
    end

    task automatic send_beat(input skt_in_t b);
        int gap;
        gap = quiet_mode ? 0 : pick_gap();
        in_data <= b;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        beats_sent++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic skt_in_t mk(logic [1:0] cmd, logic [31:0] key, logic [31:0] pay);
        skt_in_t c;
        c.cmd = cmd;
        c.entry_key = key;
        c.entry_payload = pay;
        return c;
    endfunction

    // hit_pct: share of keys taken from (or next to) keys now in the table
    function automatic logic [KEY_W-1:0] pick_key(int hit_pct);
        int               r;
        int unsigned      idx;
        logic [KEY_W-1:0] k;
        r = $urandom_range(0, 99);
        if (sb.fill > 0 && r < hit_pct)
        begin
            idx = $urandom_range(0, sb.fill - 1);
            k = sb.keys[idx];
            if ($urandom_range(0, 4) == 0)
                k = $urandom_range(0, 1) ? k + 32'd1 : k - 32'd1;
        end
        else if (r < hit_pct + 10)
        begin
            case ($urandom_range(0, 3))
                0: k = 32'h0000_0000;
                1: k = 32'h0000_0001;
                2: k = 32'hFFFF_FFFE;
                default: k = 32'hFFFF_FFFF;
            endcase
        end
        else if (r < hit_pct + 25)
            k = $urandom_range(0, 63);
        else
            k = $urandom;
        return k;
    endfunction

    function automatic skt_in_t make_cmd(cmd_mix_t mix, int hit_pct);
        skt_in_t c;
        int      r;
        r = $urandom_range(0, 99);
        case (mix)
            MIX_FILL:
                c.cmd = r < 80 ? CMD_INSERT : r < 90 ? CMD_FIND : r < 97 ? CMD_REMOVE : CMD_UNUSED;
            MIX_DRAIN:
                c.cmd = r < 80 ? CMD_REMOVE : r < 90 ? CMD_FIND : r < 98 ? CMD_INSERT : CMD_UNUSED;
            default:
                c.cmd = r < 40 ? CMD_INSERT : r < 60 ? CMD_FIND : r < 95 ? CMD_REMOVE : CMD_UNUSED;
        endcase
        c.entry_key = pick_key(hit_pct);
        r = $urandom_range(0, 99);
        c.entry_payload = r < 8 ? '0 : r < 16 ? '1 : $urandom;
        return c;
    endfunction

    initial
    begin
        int start_count;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty table, extreme keys, duplicate, misses, unused command
        send_beat(mk(CMD_FIND,   32'h0000_0005, 32'h0));
        send_beat(mk(CMD_REMOVE, 32'h0000_0005, 32'h0));
        send_beat(mk(CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_beat(mk(CMD_INSERT, 32'h8000_0000, 32'hA5A5_A5A5));
        send_beat(mk(CMD_INSERT, 32'h0000_0000, 32'h0000_0000));
        send_beat(mk(CMD_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_beat(mk(CMD_INSERT, 32'h8000_0000, 32'h0000_0001));
        send_beat(mk(CMD_INSERT, 32'h7FFF_FFFF, 32'h5A5A_5A5A));
        send_beat(mk(CMD_FIND,   32'h0000_0000, 32'h0));
        send_beat(mk(CMD_FIND,   32'hFFFF_FFFF, 32'h0));
        send_beat(mk(CMD_FIND,   32'h8000_0000, 32'h0));
        send_beat(mk(CMD_FIND,   32'h8000_0001, 32'h0));
        send_beat(mk(CMD_FIND,   32'h7FFF_FFFE, 32'h0));
        send_beat(mk(CMD_UNUSED, 32'h0000_0000, 32'h1234_5678));
        send_beat(mk(CMD_REMOVE, 32'h8000_0000, 32'h0));
        send_beat(mk(CMD_REMOVE, 32'h8000_0000, 32'h0));
        send_beat(mk(CMD_REMOVE, 32'hFFFF_FFFF, 32'h0));
        send_beat(mk(CMD_REMOVE, 32'h0000_0000, 32'h0));
        send_beat(mk(CMD_REMOVE, 32'h7FFF_FFFF, 32'h0));
        send_beat(mk(CMD_FIND,   32'h7FFF_FFFF, 32'h0));
        send_beat(mk(CMD_INSERT, 32'h0000_0001, 32'h0000_0002));

        start_count = beats_sent;

        // fill to capacity, then beat on the full table
        while (sb.fill < DEPTH && beats_sent - start_count < 700)
            send_beat(make_cmd(MIX_FILL, 10));
        repeat (40)
            send_beat(make_cmd(MIX_FILL, 50));

        // receiver holds off while the sender keeps offering
        hold_request = 1;
        repeat (6)
            send_beat(make_cmd(MIX_BALANCED, 50));

        repeat (400)
            send_beat(make_cmd(MIX_BALANCED, 50));

        // back-to-back stretch with no idling on either side
        quiet_mode = 1;
        repeat (120)
            send_beat(make_cmd(MIX_BALANCED, 50));
        quiet_mode = 0;

        repeat (400)
            send_beat(make_cmd(MIX_BALANCED, 50));

        // drain to empty
        while (sb.fill > 0 && beats_sent - start_count < RANDOM_BEATS + 400)
            send_beat(make_cmd(MIX_DRAIN, 85));

        while (beats_sent - start_count < RANDOM_BEATS)
            send_beat(make_cmd(MIX_BALANCED, 45));
        in_valid <= 1'b0;

        while (sb.due_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        sb.check_leftover();
        if (sb.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
